// File: sv/assert_macros.svh
// Assertion shorthands for RTL that checks itself; included by cone_approach_distance.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/cad_pkg.sv
// ----------------------------------------------------------------------------
// cad_pkg
// Types and constants shared by the cone approach distance block.
// ----------------------------------------------------------------------------
package cad_pkg;

	localparam int CAD_POSITION_BITS = 20;
	localparam int CFG_DATA_W = 44;
	localparam int CFG_INDEX_W = 3;
	localparam int DIR_W = 16;
	localparam int E_W = 23;
	localparam int CUT_W = 51;
	localparam int SQ_W = 64;
	localparam int PERP_W = 32;
	localparam int DIST_W = 24;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef enum logic [1:0] {
		ST_VALID = 2'd0,
		ST_NONE  = 2'd1,
		ST_FAIL  = 2'd2
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MAX_SEP_SQ  = 3'd0,
		CFG_MAX_PROJ    = 3'd1,
		CFG_MIN_PROJ    = 3'd2,
		CFG_TAN_FINE    = 3'd3,
		CFG_TAN_COARSE  = 3'd4,
		CFG_PAD_FINE    = 3'd5,
		CFG_PAD_COARSE  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [43:0]        max_separation_sq;
		logic signed [19:0] max_projection;
		logic signed [19:0] min_projection;
		logic [15:0]        tan_cone_fine;
		logic [15:0]        tan_cone_coarse;
		logic [15:0]        pad_widths_fine;
		logic [15:0]        pad_widths_coarse;
	} cad_cfg_t;

	// Word handed from the front to the back: status so far, the sum of
	// squared cross magnitudes and the cut.
	typedef struct packed {
		status_t           status;
		logic [SQ_W-1:0]   sq_sum;
		logic [CUT_W-1:0]  cut;
	} cad_word_t;

endpackage

// File: sv/cone_approach_distance.sv
// ----------------------------------------------------------------------------
// cone_approach_distance
// Normalized cone distance between a calorimeter hit and a reference point.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle whenever busy is low (busy is high
// only in the first cycle after reset) and returns exactly one result word per
// input, in order, on a one-cycle strobe. Between input and result lie six
// front stages, one queue slot, 32 square root stages (one root bit each) and
// 26 divider and output stages (one quotient bit per divider stage).
// Configuration writes take effect at once and should be made
// while no word is in flight.
module cone_approach_distance #(
	parameter int POSITION_BITS = cad_pkg::CAD_POSITION_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [POSITION_BITS-1:0]      hit_x,
	input  logic signed [POSITION_BITS-1:0]      hit_y,
	input  logic signed [POSITION_BITS-1:0]      hit_z,
	input  logic signed [POSITION_BITS-1:0]      ref_x,
	input  logic signed [POSITION_BITS-1:0]      ref_y,
	input  logic signed [POSITION_BITS-1:0]      ref_z,
	input  logic signed [cad_pkg::DIR_W-1:0]     dir_x,
	input  logic signed [cad_pkg::DIR_W-1:0]     dir_y,
	input  logic signed [cad_pkg::DIR_W-1:0]     dir_z,
	input  logic [15:0]                          cell_size,
	input  logic                                 fine_cell,
	input  logic                                 cfg_we,
	input  logic [cad_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [cad_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                 strobe,
	output logic [1:0]                           status,
	output logic [cad_pkg::DIST_W-1:0]           distance
);

	`include "assert_macros.svh"

	cad_pkg::cad_cfg_t  cfg_q;
	logic               busy_q;
	logic               front_valid;
	cad_pkg::cad_word_t front_word;
	logic               q_not_empty, q_full;
	cad_pkg::cad_word_t q_word;

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			cfg_q.max_separation_sq <= 44'd256000000;
			cfg_q.max_projection <= 20'sd3200;
			cfg_q.min_projection <= -20'sd160;
			cfg_q.tan_cone_fine <= 16'd1229;
			cfg_q.tan_cone_coarse <= 16'd2048;
			cfg_q.pad_widths_fine <= 16'd10240;
			cfg_q.pad_widths_coarse <= 16'd10240;
		end else begin
			busy_q <= 1'b0;
			if (cfg_we) begin
				case (cad_pkg::cfg_idx_t'(cfg_index))
					cad_pkg::CFG_MAX_SEP_SQ: cfg_q.max_separation_sq <= cfg_data;
					cad_pkg::CFG_MAX_PROJ:   cfg_q.max_projection <= cfg_data[19:0];
					cad_pkg::CFG_MIN_PROJ:   cfg_q.min_projection <= cfg_data[19:0];
					cad_pkg::CFG_TAN_FINE:   cfg_q.tan_cone_fine <= cfg_data[15:0];
					cad_pkg::CFG_TAN_COARSE: cfg_q.tan_cone_coarse <= cfg_data[15:0];
					cad_pkg::CFG_PAD_FINE:   cfg_q.pad_widths_fine <= cfg_data[15:0];
					cad_pkg::CFG_PAD_COARSE: cfg_q.pad_widths_coarse <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	cad_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy_q),
		.hit_x     (hit_x),
		.hit_y     (hit_y),
		.hit_z     (hit_z),
		.ref_x     (ref_x),
		.ref_y     (ref_y),
		.ref_z     (ref_z),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.cell_size (cell_size),
		.fine_cell (fine_cell),
		.cfg       (cfg_q),
		.out_valid (front_valid),
		.out_word  (front_word)
	);

	cad_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_word (front_word),
		.pop       (1'b1),
		.not_empty (q_not_empty),
		.full      (q_full),
		.pop_word  (q_word)
	);

	cad_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_not_empty),
		.in_word  (q_word),
		.strobe   (strobe),
		.status   (status),
		.distance (distance)
	);

	// The back drains the queue every cycle, so a push never meets a full queue.
	`ASSERT_IMPLIES(a_queue_no_overflow, front_valid, !q_full, "queue overflow")
	`ASSERT_IMPLIES(a_invalid_zero, strobe && (status != cad_pkg::ST_VALID),
		distance == '0, "nonzero distance on invalid status")
	`ASSERT_NEXT(a_busy_stays_low, !busy, !busy, "busy rose after reset")

endmodule

// File: sv/cad_front.sv
// ----------------------------------------------------------------------------
// cad_front
// Six-stage front: difference vector, separation and window tests, cut and
// the squared cross product magnitudes. Takes one word per cycle.
// ----------------------------------------------------------------------------
module cad_front #(
	parameter int POSITION_BITS = cad_pkg::CAD_POSITION_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [POSITION_BITS-1:0]   hit_x,
	input  logic signed [POSITION_BITS-1:0]   hit_y,
	input  logic signed [POSITION_BITS-1:0]   hit_z,
	input  logic signed [POSITION_BITS-1:0]   ref_x,
	input  logic signed [POSITION_BITS-1:0]   ref_y,
	input  logic signed [POSITION_BITS-1:0]   ref_z,
	input  logic signed [cad_pkg::DIR_W-1:0]  dir_x,
	input  logic signed [cad_pkg::DIR_W-1:0]  dir_y,
	input  logic signed [cad_pkg::DIR_W-1:0]  dir_z,
	input  logic [15:0]                       cell_size,
	input  logic                              fine_cell,
	input  cad_pkg::cad_cfg_t                 cfg,
	output logic                              out_valid,
	output cad_pkg::cad_word_t                out_word
);

	localparam int EXT_W = (POSITION_BITS + 1 > 24) ? POSITION_BITS + 1 : 24;
	localparam int EW = cad_pkg::E_W;
	localparam int PW = cad_pkg::DIR_W + EW;

	// Stage 1
	logic                       v_s1;
	logic signed [EW-1:0]       e_s1 [3];
	logic                       far_s1;
	logic signed [cad_pkg::DIR_W-1:0] d_s1 [3];
	logic [15:0]                cell_s1;
	logic                       fine_s1;
	// Stage 2
	logic                       v_s2;
	logic                       far_s2;
	logic [2*(EW-1)-1:0]        sq_s2 [3];
	logic signed [PW-1:0]       al_s2 [3];
	logic signed [PW-1:0]       xp_s2 [6];
	logic [15:0]                cell_s2;
	logic                       fine_s2;
	// Stage 3
	logic                       v_s3;
	logic                       sep_ok_s3;
	logic signed [PW+1:0]       along_s3;
	logic [30:0]                cm_s3 [3];
	logic [15:0]                cell_s3;
	logic                       fine_s3;
	// Stage 4
	logic                       v_s4;
	logic                       ok_s4;
	logic [33:0]                absal_s4;
	logic [15:0]                tan_s4;
	logic [31:0]                padcell_s4;
	logic [61:0]                csq_s4 [3];
	// Stage 5
	logic                       v_s5;
	logic                       ok_s5;
	logic [49:0]                cutp_s5;
	logic [31:0]                padcell_s5;
	logic [cad_pkg::SQ_W-1:0]   sq_s5;

	logic signed [POSITION_BITS-1:0] hit_a [3];
	logic signed [POSITION_BITS-1:0] ref_a [3];
	logic signed [cad_pkg::DIR_W-1:0] dir_a [3];
	logic signed [EXT_W-1:0]    ex [3];
	logic [2:0]                 far_a;

	assign hit_a = '{hit_x, hit_y, hit_z};
	assign ref_a = '{ref_x, ref_y, ref_z};
	assign dir_a = '{dir_x, dir_y, dir_z};

	// A component is far when its magnitude reaches 2^22.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ex[i] = EXT_W'(hit_a[i]) - EXT_W'(ref_a[i]);
			far_a[i] = !((&ex[i][EXT_W-1:EW-1]) || !(|ex[i][EXT_W-1:EW-1]))
				|| ((&ex[i][EXT_W-1:EW-1]) && !(|ex[i][EW-2:0]));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			e_s1[i] <= ex[i][EW-1:0];
			d_s1[i] <= dir_a[i];
		end
		far_s1 <= |far_a;
		cell_s1 <= cell_size;
		fine_s1 <= fine_cell;
	end

	// Stage 2: all products.
	logic [EW-2:0] me [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			me[i] = e_s1[i][EW-1] ? (EW-1)'(-e_s1[i]) : e_s1[i][EW-2:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= me[i] * me[i];
			al_s2[i] <= d_s1[i] * e_s1[i];
		end
		xp_s2[0] <= d_s1[1] * e_s1[2];
		xp_s2[1] <= d_s1[2] * e_s1[1];
		xp_s2[2] <= d_s1[2] * e_s1[0];
		xp_s2[3] <= d_s1[0] * e_s1[2];
		xp_s2[4] <= d_s1[0] * e_s1[1];
		xp_s2[5] <= d_s1[1] * e_s1[0];
		far_s2 <= far_s1;
		cell_s2 <= cell_s1;
		fine_s2 <= fine_s1;
	end

	// Stage 3: separation test, projection sum, cross magnitudes.
	logic [2*(EW-1)+1:0] sep;
	logic signed [PW:0]  cx [3];
	logic [PW-1:0]       cxm [3];
	always_comb begin
		sep = (2*(EW-1)+2)'(sq_s2[0]) + (2*(EW-1)+2)'(sq_s2[1])
			+ (2*(EW-1)+2)'(sq_s2[2]);
		for (int i = 0; i < 3; i++) begin
			cx[i] = (PW+1)'(xp_s2[2*i]) - (PW+1)'(xp_s2[2*i+1]);
			cxm[i] = cx[i][PW] ? PW'(-cx[i]) : cx[i][PW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		sep_ok_s3 <= !far_s2 && (sep <= (2*(EW-1)+2)'(cfg.max_separation_sq));
		along_s3 <= (PW+2)'(al_s2[0]) + (PW+2)'(al_s2[1]) + (PW+2)'(al_s2[2]);
		for (int i = 0; i < 3; i++) begin
			cm_s3[i] <= cxm[i][37:7];
		end
		cell_s3 <= cell_s2;
		fine_s3 <= fine_s2;
	end

	// Stage 4: projection window, constant select, pad term, squares.
	logic signed [PW+1:0] hi_ext, lo_ext;
	logic [PW+1:0]        abs_along;
	logic [15:0]          tan_sel, pad_sel;
	always_comb begin
		hi_ext = (PW+2)'(signed'({cfg.max_projection, 15'b0}));
		lo_ext = (PW+2)'(signed'({cfg.min_projection, 15'b0}));
		abs_along = along_s3[PW+1] ? (PW+2)'(-along_s3) : along_s3;
		tan_sel = fine_s3 ? cfg.tan_cone_fine : cfg.tan_cone_coarse;
		pad_sel = fine_s3 ? cfg.pad_widths_fine : cfg.pad_widths_coarse;
	end

	always_ff @(posedge clk) begin
		ok_s4 <= sep_ok_s3 && (along_s3 < hi_ext) && (along_s3 > lo_ext);
		absal_s4 <= abs_along[33:0];
		tan_s4 <= tan_sel;
		padcell_s4 <= pad_sel * cell_s3;
		for (int i = 0; i < 3; i++) begin
			csq_s4[i] <= cm_s3[i] * cm_s3[i];
		end
	end

	// Stage 5: along term of the cut and the sum of squares.
	always_ff @(posedge clk) begin
		ok_s5 <= ok_s4;
		cutp_s5 <= absal_s4 * tan_s4;
		padcell_s5 <= padcell_s4;
		sq_s5 <= cad_pkg::SQ_W'(csq_s4[0]) + cad_pkg::SQ_W'(csq_s4[1])
			+ cad_pkg::SQ_W'(csq_s4[2]);
	end

	// Stage 6: cut and status.
	logic [cad_pkg::CUT_W-1:0] cut;
	assign cut = cad_pkg::CUT_W'(cutp_s5) + cad_pkg::CUT_W'({padcell_s5, 15'b0});

	always_ff @(posedge clk) begin
		if (!ok_s5) begin
			out_word.status <= cad_pkg::ST_NONE;
		end else if (cut == '0) begin
			out_word.status <= cad_pkg::ST_FAIL;
		end else begin
			out_word.status <= cad_pkg::ST_VALID;
		end
		out_word.sq_sum <= sq_s5;
		out_word.cut <= cut;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			out_valid <= v_s5;
		end
	end

endmodule

// File: sv/cad_queue.sv
// ----------------------------------------------------------------------------
// cad_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module cad_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cad_pkg::cad_word_t push_word,
	input  logic               pop,
	output logic               not_empty,
	output logic               full,
	output cad_pkg::cad_word_t pop_word
);

	cad_pkg::cad_word_t entry_q [2];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         count_q;

	logic do_pop;
	assign do_pop = pop && (count_q != 2'd0);
	assign not_empty = (count_q != 2'd0);
	assign full = (count_q == 2'd2);
	assign pop_word = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'((push && !full) ? 1 : 0) - 2'(do_pop ? 1 : 0);
		end
	end

endmodule

// File: sv/cad_back.sv
// ----------------------------------------------------------------------------
// cad_back
// Back end: pipelined integer square root (one result bit per stage) and a
// pipelined restoring divider (one quotient bit per stage) with saturation.
// ----------------------------------------------------------------------------
module cad_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  cad_pkg::cad_word_t             in_word,
	output logic                           strobe,
	output logic [1:0]                     status,
	output logic [cad_pkg::DIST_W-1:0]     distance
);

	localparam int SQ_W = cad_pkg::SQ_W;
	localparam int CUT_W = cad_pkg::CUT_W;
	localparam int NSTG = cad_pkg::PERP_W;
	localparam int DW = cad_pkg::DIST_W;
	localparam int NUM_W = cad_pkg::PERP_W + 35;
	localparam int CMP_W = CUT_W + DW + 1;

	logic [SQ_W-1:0]       rem_s  [NSTG];
	logic [SQ_W-1:0]       root_s [NSTG];
	logic [CUT_W-1:0]      scut_s [NSTG];
	cad_pkg::status_t      sst_s  [NSTG];
	logic [NSTG-1:0]       sv_s;

	genvar k;
	generate
		for (k = 0; k < NSTG; k++) begin : g_sqrt
			localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (62 - 2 * k);
			logic [SQ_W-1:0]  rem_in, root_in;
			logic [CUT_W-1:0] cut_in;
			cad_pkg::status_t st_in;
			logic             v_in;
			logic [SQ_W:0]    trial;
			logic             ge;
			if (k == 0) begin : g_first
				assign rem_in = in_word.sq_sum;
				assign root_in = '0;
				assign cut_in = in_word.cut;
				assign st_in = in_word.status;
				assign v_in = in_valid;
			end else begin : g_next
				assign rem_in = rem_s[k-1];
				assign root_in = root_s[k-1];
				assign cut_in = scut_s[k-1];
				assign st_in = sst_s[k-1];
				assign v_in = sv_s[k-1];
			end
			assign trial = {1'b0, root_in} + {1'b0, BITV};
			assign ge = ({1'b0, rem_in} >= trial);
			always_ff @(posedge clk) begin
				rem_s[k] <= ge ? rem_in - trial[SQ_W-1:0] : rem_in;
				root_s[k] <= ge ? (root_in >> 1) + BITV : root_in >> 1;
				scut_s[k] <= cut_in;
				sst_s[k] <= st_in;
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					sv_s[k] <= 1'b0;
				end else begin
					sv_s[k] <= v_in;
				end
			end
		end
	endgenerate

	// Divider entry: numerator perp * 2^35 and the saturation test.
	logic [NUM_W-1:0]      num;
	logic                  sat;
	logic [NUM_W-1:0]      r_s1;
	logic [CUT_W-1:0]      c_s1;
	logic                  sat_s1;
	cad_pkg::status_t      st_s1;
	logic                  v_s1;

	assign num = {root_s[NSTG-1][cad_pkg::PERP_W-1:0], 35'b0};
	assign sat = (CMP_W'(num) >= {1'b0, scut_s[NSTG-1], DW'(0)});

	always_ff @(posedge clk) begin
		r_s1 <= num;
		c_s1 <= scut_s[NSTG-1];
		sat_s1 <= sat;
		st_s1 <= sst_s[NSTG-1];
	end

	logic [NUM_W-1:0]      dr_s  [DW];
	logic [DW-1:0]         dq_s  [DW];
	logic [CUT_W-1:0]      dc_s  [DW];
	logic                  dsat_s [DW];
	cad_pkg::status_t      dst_s [DW];
	logic [DW-1:0]         dv_s;

	generate
		for (k = 0; k < DW; k++) begin : g_div
			localparam int SH = DW - 1 - k;
			logic [NUM_W-1:0] r_in;
			logic [DW-1:0]    q_in;
			logic [CUT_W-1:0] c_in;
			logic             sat_in;
			cad_pkg::status_t st_in;
			logic             v_in;
			logic [CMP_W-1:0] dvs;
			logic             ge;
			if (k == 0) begin : g_first
				assign r_in = r_s1;
				assign q_in = '0;
				assign c_in = c_s1;
				assign sat_in = sat_s1;
				assign st_in = st_s1;
				assign v_in = v_s1;
			end else begin : g_next
				assign r_in = dr_s[k-1];
				assign q_in = dq_s[k-1];
				assign c_in = dc_s[k-1];
				assign sat_in = dsat_s[k-1];
				assign st_in = dst_s[k-1];
				assign v_in = dv_s[k-1];
			end
			assign dvs = CMP_W'(c_in) << SH;
			assign ge = (CMP_W'(r_in) >= dvs);
			always_ff @(posedge clk) begin
				dr_s[k] <= ge ? r_in - dvs[NUM_W-1:0] : r_in;
				dq_s[k] <= ge ? (q_in | (DW'(1) << SH)) : q_in;
				dc_s[k] <= c_in;
				dsat_s[k] <= sat_in;
				dst_s[k] <= st_in;
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dv_s[k] <= 1'b0;
				end else begin
					dv_s[k] <= v_in;
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		status <= dst_s[DW-1];
		if (dst_s[DW-1] != cad_pkg::ST_VALID) begin
			distance <= '0;
		end else if (dsat_s[DW-1]) begin
			distance <= cad_pkg::DIST_MAX;
		end else begin
			distance <= dq_s[DW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			strobe <= 1'b0;
		end else begin
			v_s1 <= sv_s[NSTG-1];
			strobe <= dv_s[DW-1];
		end
	end

endmodule
